// File: src/kor_pkg.sv
package kor_pkg;

  // Number of priority table entries in use (limited to the table length).
  localparam int KEY_ENTRIES = 18;
  localparam int TABLE_LEN   = 18;
  localparam int KEY_CNT     = (KEY_ENTRIES < TABLE_LEN) ? KEY_ENTRIES : TABLE_LEN;

  localparam logic [31:0] MASK_G0   = 32'h000F_FC0F;
  localparam logic [31:0] MASK_G1   = 32'h0020_0000;
  localparam logic [31:0] MASK_G2   = 32'h0000_2182;
  localparam int          USB_POS   = 26;
  localparam int          SD_RO_POS = 17;

  localparam logic [15:0] FIRST_DELAY_RST  = 16'd500;
  localparam logic [15:0] REPEAT_DELAY_RST = 16'd175;

  localparam int TDATA_IN_W  = 136;
  localparam int TDATA_OUT_W = 136;

  typedef enum logic [2:0] {
    OP_SCAN    = 3'd0,
    OP_PRESS   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_REL_ALL = 3'd3,
    OP_RST_REP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CFG_REMOTE_EN  = 2'd0,
    CFG_FIRST_DLY  = 2'd1,
    CFG_REPEAT_DLY = 2'd2
  } cfg_idx_e;

  typedef logic [2:0][31:0] kwords_t;

  typedef struct packed {
    op_e         op;
    logic [4:0]  key_code;
    kwords_t     raw;
    logic        override_on;
    logic [31:0] tick_ms;
  } item_t;

  typedef struct packed {
    logic [31:0] status0;
    logic [31:0] status1;
    logic [31:0] status2;
    logic        remote_level;
    logic [15:0] pulse_length;
    logic [4:0]  pressed_key;
    logic [4:0]  clicked_key;
    logic [4:0]  repeat_key;
    logic        key_is_clicked;
  } result_t;

  typedef struct packed {
    logic        remote_en;
    logic [15:0] first_delay;
    logic [15:0] repeat_delay;
  } cfg_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  grp;
    logic [31:0] bits;
  } key_ref_t;

  localparam logic [1:0] KEY_GRP [TABLE_LEN] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2
  };

  localparam logic [4:0] KEY_CODE [TABLE_LEN] = '{
    5'd1, 5'd2, 5'd1, 5'd3, 5'd4, 5'd3, 5'd5, 5'd6, 5'd7,
    5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16
  };

  localparam logic [31:0] KEY_BITS [TABLE_LEN] = '{
    32'h0000_0003, 32'h0000_0001, 32'h0000_0002,
    32'h0000_000C, 32'h0000_0004, 32'h0000_0008,
    32'h0000_0800, 32'h0000_1000, 32'h0000_6000,
    32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
    32'h0008_0000, 32'h0020_0000, 32'h0000_0100,
    32'h0000_2002, 32'h0000_0002, 32'h0000_2000
  };

  // First table entry that carries the given code.
  function automatic key_ref_t find_key(logic [4:0] code);
    key_ref_t r;
    r = '0;
    for (int i = 0; i < KEY_CNT; i++) begin
      if (!r.found && KEY_CODE[i] == code) begin
        r.found = 1'b1;
        r.grp   = KEY_GRP[i];
        r.bits  = KEY_BITS[i];
      end
    end
    return r;
  endfunction

  function automatic logic is_pressed(kwords_t cur, logic [1:0] grp, logic [31:0] bits);
    return (cur[grp] & bits) == '0;
  endfunction

  function automatic logic is_clicked(kwords_t cur, kwords_t prev, logic [1:0] grp,
                                      logic [31:0] bits);
    return ((prev[grp] & bits) != '0) && ((cur[grp] & bits) == '0);
  endfunction

  function automatic logic [4:0] first_pressed(kwords_t cur);
    logic [4:0] code;
    code = '0;
    for (int i = 0; i < KEY_CNT; i++) begin
      if (code == '0 && is_pressed(cur, KEY_GRP[i], KEY_BITS[i])) begin
        code = KEY_CODE[i];
      end
    end
    return code;
  endfunction

  function automatic logic [4:0] first_clicked(kwords_t cur, kwords_t prev);
    logic [4:0] code;
    code = '0;
    for (int i = 0; i < KEY_CNT; i++) begin
      if (code == '0 && is_clicked(cur, prev, KEY_GRP[i], KEY_BITS[i])) begin
        code = KEY_CODE[i];
      end
    end
    return code;
  endfunction

endpackage

// File: src/key_override_autorepeat.sv
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+-----------------------------------
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tuser: operation; tdata: item
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: result
// cfg      | in        | cfg_we_i (no wait)           | cfg_idx_i, cfg_wdata_i
//
// One request is taken per cycle while the result stream is not stalled, and each request gives exactly one result.
// A request is first held in the input register, and the evaluation of the
// key words, the override merge and the autorepeat happens on the way into
// the result register, from which the result is offered on m_axis.
// Reset is asynchronous and active low: the key words return to all ones,
// the autorepeat and the remote counter clear, and the registers load their
// defaults (remote off, first delay 500, repeat delay 175).
// When m_axis_tready is low with a result waiting the result register holds;
// the input register still takes one more request, and s_axis_tready drops once both are full.
module key_override_autorepeat import kor_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [4:0] key_code, [36:5] raw_word0, [68:37] raw_word1, [100:69] raw_word2,
  // [101] override_on, [133:102] tick_ms, [135:134] zero
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
  // [2:0] operation
  input  logic [2:0]             s_axis_tuser,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] status0, [63:32] status1, [95:64] status2, [96] remote_level,
  // [112:97] pulse_length, [117:113] pressed_key, [122:118] clicked_key,
  // [127:123] repeat_key, [128] key_is_clicked, [135:129] zero
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [15:0]            cfg_wdata_i
);

  item_t   in_item, stage_item;
  logic    stage_valid, adv;
  result_t core_res, out_q;
  logic    out_valid_q, out_valid_d;
  cfg_t    cfg_q, cfg_d;

  // Unpack the request fields.
  assign in_item.op          = op_e'(s_axis_tuser);
  assign in_item.key_code    = s_axis_tdata[4:0];
  assign in_item.raw[0]      = s_axis_tdata[36:5];
  assign in_item.raw[1]      = s_axis_tdata[68:37];
  assign in_item.raw[2]      = s_axis_tdata[100:69];
  assign in_item.override_on = s_axis_tdata[101];
  assign in_item.tick_ms     = s_axis_tdata[133:102];

  // An item moves on when the result register is empty or being drained.
  assign adv = stage_valid && (!out_valid_q || m_axis_tready);

  kor_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .adv_i      (adv),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  kor_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .item_i   (stage_item),
    .cfg_i    (cfg_q),
    .result_o (core_res)
  );

  // Configuration registers; writes to an unused index are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REMOTE_EN:  cfg_d.remote_en    = cfg_wdata_i[0];
        CFG_FIRST_DLY:  cfg_d.first_delay  = cfg_wdata_i;
        CFG_REPEAT_DLY: cfg_d.repeat_delay = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.remote_en    <= 1'b0;
      cfg_q.first_delay  <= FIRST_DELAY_RST;
      cfg_q.repeat_delay <= REPEAT_DELAY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || m_axis_tready) begin
      out_valid_d = adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.key_is_clicked, out_q.repeat_key, out_q.clicked_key,
                          out_q.pressed_key, out_q.pulse_length, out_q.remote_level,
                          out_q.status2, out_q.status1, out_q.status0};

  // A clicked key is also pressed, so the pressed priority search finds one.
  a_click_implies_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.clicked_key != '0) |-> (out_q.pressed_key != '0))
    else $error("clicked key reported without a pressed key");

  // A pulse length is only reported on the scan where the remote level falls.
  a_pulse_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.pulse_length != '0) |-> !out_q.remote_level)
    else $error("pulse length reported while remote level is high");

  // The SD read-only flag never reaches the reported status.
  a_sd_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !out_q.status2[SD_RO_POS])
    else $error("SD read-only bit set in reported status");

endmodule

// File: src/kor_in_reg.sv
module kor_in_reg import kor_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  adv_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // The register takes a new request when empty or when its item moves on.
  assign in_ready_o = !valid_q || adv_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/kor_core.sv
module kor_core import kor_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  kwords_t     cur_q, cur_d, prev_q, prev_d, virt_q, virt_d;
  logic [4:0]  held_key_q, held_key_d;
  logic [31:0] held_since_q, held_since_d;
  logic        repeating_q, repeating_d;
  logic [15:0] rhc_q, rhc_d;

  key_ref_t    code_ref, held_ref;
  kwords_t     stat;
  logic [4:0]  clk_key;
  logic [31:0] wait_ticks, elapsed;
  result_t     res;

  always_comb begin
    cur_d        = cur_q;
    prev_d       = prev_q;
    virt_d       = virt_q;
    held_key_d   = held_key_q;
    held_since_d = held_since_q;
    repeating_d  = repeating_q;
    rhc_d        = rhc_q;
    res          = '0;
    stat         = '0;
    code_ref     = find_key(item_i.key_code);
    held_ref     = find_key(held_key_q);
    clk_key      = '0;
    wait_ticks   = {16'd0, repeating_q ? cfg_i.repeat_delay : cfg_i.first_delay};
    elapsed      = item_i.tick_ms - held_since_q;

    case (item_i.op)
      OP_SCAN: begin
        prev_d = cur_q;
        cur_d  = item_i.raw;
        if (item_i.override_on) begin
          stat[0] = (cur_d[0] | MASK_G0) & (~MASK_G0 | virt_q[0]);
          stat[1] = (cur_d[1] | MASK_G1) & (~MASK_G1 | virt_q[1]);
          stat[2] = (cur_d[2] | MASK_G2) & (~MASK_G2 | virt_q[2]);
        end else begin
          stat = cur_d;
        end
        res.remote_level = stat[2][USB_POS];
        if (stat[2][USB_POS]) begin
          if (rhc_q != 16'hFFFF) begin
            rhc_d = rhc_q + 16'd1;
          end
        end else if (rhc_q != '0) begin
          res.pulse_length = rhc_q;
          rhc_d            = '0;
        end
        if (cfg_i.remote_en) begin
          stat[2][USB_POS] = 1'b0;
        end
        stat[2][SD_RO_POS] = 1'b0;

        // Autorepeat: a fresh click restarts the hold timer, otherwise a held
        // key repeats once its delay has strictly passed.
        clk_key = first_clicked(cur_d, prev_d);
        if (clk_key != '0) begin
          held_key_d     = clk_key;
          repeating_d    = 1'b0;
          held_since_d   = item_i.tick_ms;
          res.repeat_key = clk_key;
        end else if (held_key_q != '0 && held_ref.found &&
                     is_pressed(cur_d, held_ref.grp, held_ref.bits)) begin
          if (elapsed > wait_ticks) begin
            repeating_d    = 1'b1;
            held_since_d   = item_i.tick_ms;
            res.repeat_key = held_key_q;
          end
        end else begin
          held_key_d = '0;
        end
      end
      OP_PRESS: begin
        if (code_ref.found) begin
          virt_d[code_ref.grp] = virt_q[code_ref.grp] & ~code_ref.bits;
        end
      end
      OP_RELEASE: begin
        if (code_ref.found) begin
          virt_d[code_ref.grp] = virt_q[code_ref.grp] | code_ref.bits;
        end
      end
      OP_REL_ALL: begin
        virt_d[0] = virt_q[0] | MASK_G0;
        virt_d[1] = virt_q[1] | MASK_G1;
        virt_d[2] = virt_q[2] | MASK_G2;
      end
      OP_RST_REP: begin
        held_key_d = '0;
      end
      default: begin
      end
    endcase

    res.status0        = stat[0];
    res.status1        = stat[1];
    res.status2        = stat[2];
    res.pressed_key    = first_pressed(cur_d);
    res.clicked_key    = first_clicked(cur_d, prev_d);
    res.key_is_clicked = code_ref.found &&
                         is_clicked(cur_d, prev_d, code_ref.grp, code_ref.bits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q        <= '1;
      prev_q       <= '1;
      virt_q       <= '1;
      held_key_q   <= '0;
      held_since_q <= '0;
      repeating_q  <= 1'b0;
      rhc_q        <= '0;
    end else if (adv_i) begin
      cur_q        <= cur_d;
      prev_q       <= prev_d;
      virt_q       <= virt_d;
      held_key_q   <= held_key_d;
      held_since_q <= held_since_d;
      repeating_q  <= repeating_d;
      rhc_q        <= rhc_d;
    end
  end

  assign result_o = res;

endmodule
